@@ rtl/mmn_pkg.sv @@
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared types and constants of the min-max byte normalizer: frame size,
// sample and counter widths, divider widths and the gray request struct.
// ----------------------------------------------------------------------------
package mmn_pkg;

  localparam int unsigned MAX_PIXELS  = 131072;
  localparam int unsigned SAMPLE_BITS = 16;

  localparam int unsigned IDX_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam int unsigned PIXEL_COUNT_W = 18;
  localparam logic [PIXEL_COUNT_W-1:0] PIXEL_COUNT_RESET = PIXEL_COUNT_W'(102400);

  localparam int unsigned GRAY_W = 8;
  localparam logic [GRAY_W-1:0] GRAY_FULL = GRAY_W'(255);

  // dividend 510*n + d stays below 511 * 2^SAMPLE_BITS
  localparam int unsigned NUM_W   = SAMPLE_BITS + 9;
  localparam int unsigned STEP_W  = $clog2(GRAY_W);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_TOP =
    {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_BOTTOM =
    {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EMIT = 1'b1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [SAMPLE_BITS-1:0] vmin;
    logic signed [SAMPLE_BITS-1:0] vmax;
  } gray_req_t;

endpackage

@@ rtl/mmn_ram.sv @@
// ----------------------------------------------------------------------------
// mmn_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module mmn_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                        clk_i,
  input  logic                                        en_i,
  input  logic                                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                            wdata_i,
  output logic [WIDTH-1:0]                            rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mmn_div.sv @@
// ----------------------------------------------------------------------------
// mmn_div
// Gray value unit: forms n = v - min and d = max - min, handles the flat and
// out-of-range cases, then runs an 8-step restoring division of
// (510*n + d) by 2*d to get round((v-min)*255/(max-min)) half up.
// ----------------------------------------------------------------------------
module mmn_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  mmn_pkg::gray_req_t         req_i,
  output logic                       done_o,
  output logic [mmn_pkg::GRAY_W-1:0] gray_o
);
  import mmn_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_STEP
  } state_e;

  state_e                     state_q, state_d;
  logic signed [SAMPLE_BITS:0] n_q, n_d;
  logic signed [SAMPLE_BITS:0] d_q, d_d;
  logic [NUM_W-1:0]           rem_q, rem_d;
  logic [NUM_W-1:0]           dv_q, dv_d;
  logic [GRAY_W-1:0]          quo_q, quo_d;
  logic [STEP_W-1:0]          step_q, step_d;
  logic [GRAY_W-1:0]          gray_q, gray_d;
  logic                       done_q, done_d;

  logic [NUM_W-1:0] n_ext;
  logic [NUM_W-1:0] d_ext;
  logic             fits;

  assign n_ext = NUM_W'($unsigned(n_q));
  assign d_ext = NUM_W'($unsigned(d_q));
  assign fits  = (rem_q >= dv_q);

  always_comb begin
    state_d = state_q;
    n_d     = n_q;
    d_d     = d_q;
    rem_d   = rem_q;
    dv_d    = dv_q;
    quo_d   = quo_q;
    step_d  = step_q;
    gray_d  = gray_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          n_d     = {req_i.sample[SAMPLE_BITS-1], req_i.sample}
                  - {req_i.vmin[SAMPLE_BITS-1], req_i.vmin};
          d_d     = {req_i.vmax[SAMPLE_BITS-1], req_i.vmax}
                  - {req_i.vmin[SAMPLE_BITS-1], req_i.vmin};
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        if (d_q <= 0 || n_q <= 0) begin
          gray_d  = '0;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else if (n_q >= d_q) begin
          gray_d  = GRAY_FULL;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          // 510*n + d, divisor 2*d aligned to the top quotient bit
          rem_d   = (n_ext << 9) - (n_ext << 1) + d_ext;
          dv_d    = d_ext << GRAY_W;
          quo_d   = '0;
          step_d  = '0;
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        if (fits) begin
          rem_d = rem_q - dv_q;
        end
        quo_d  = {quo_q[GRAY_W-2:0], fits};
        dv_d   = dv_q >> 1;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(GRAY_W - 1)) begin
          gray_d  = quo_d;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      step_q  <= '0;
      n_q     <= '0;
      d_q     <= '0;
      rem_q   <= '0;
      dv_q    <= '0;
      quo_q   <= '0;
      gray_q  <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      step_q  <= step_d;
      n_q     <= n_d;
      d_q     <= d_d;
      rem_q   <= rem_d;
      dv_q    <= dv_d;
      quo_q   <= quo_d;
      gray_q  <= gray_d;
    end
  end

  assign done_o = done_q;
  assign gray_o = gray_q;

endmodule

@@ rtl/minmax_normalize_to_byte.sv @@
// ----------------------------------------------------------------------------
// minmax_normalize_to_byte
// Loads a frame of signed samples into the frame memory while tracking the
// running minimum and maximum, then returns each stored pixel on request as
// an 8-bit gray value scaled between those bounds.
//
//   channel  direction  handshake               payload
//   in       input      in_valid_i/in_stall_o   mode_i, sample_i
//   out      output     out_valid_o/out_stall_i gray_o, last_o
//   cfg      input      cfg_we_i                cfg_wdata_i (pixel_count)
//
// loads can follow back to back
// a request stalls the input through read, prep, 8 divider steps, done and
// output load; the divider steps are skipped when the range is flat or v lies outside it
// a stalled output parks the next finished request and the input waits
// reset starts the load phase; frame memory needs no clearing pass
// ----------------------------------------------------------------------------
module minmax_normalize_to_byte (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [mmn_pkg::PIXEL_COUNT_W-1:0]        cfg_wdata_i,
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic                                     mode_i,
  input  logic signed [mmn_pkg::SAMPLE_BITS-1:0]   sample_i,
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic [mmn_pkg::GRAY_W-1:0]               gray_o,
  output logic                                     last_o
);
  import mmn_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_EMIT
  } state_e;

  state_e                         state_q, state_d;
  logic [PIXEL_COUNT_W-1:0]       pixel_count_q, pixel_count_d;
  logic signed [SAMPLE_BITS-1:0]  run_min_q, run_min_d;
  logic signed [SAMPLE_BITS-1:0]  run_max_q, run_max_d;
  logic [IDX_W-1:0]               load_cnt_q, load_cnt_d;
  logic [IDX_W-1:0]               emit_ptr_q, emit_ptr_d;
  logic                           emitting_q, emitting_d;
  logic signed [SAMPLE_BITS-1:0]  req_min_q, req_min_d;
  logic signed [SAMPLE_BITS-1:0]  req_max_q, req_max_d;
  logic                           last_pend_q, last_pend_d;
  logic                           out_valid_q, out_valid_d;
  logic [GRAY_W-1:0]              out_gray_q, out_gray_d;
  logic                           out_last_q, out_last_d;

  logic                  in_xfer;
  logic                  out_free;
  logic [31:0]           pc_ext;
  logic [CNT_W-1:0]      frame_len;
  logic [CNT_W-1:0]      load_next;
  logic [CNT_W-1:0]      emit_next;
  logic                  ram_en;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_addr;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                  div_start;
  gray_req_t             div_req;
  logic                  div_done;
  logic [GRAY_W-1:0]     div_gray;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // pixel count clamped to 1..MAX_PIXELS
  assign pc_ext = 32'(pixel_count_q);
  always_comb begin
    if (pc_ext == 32'd0) begin
      frame_len = CNT_W'(1);
    end else if (pc_ext > 32'(MAX_PIXELS)) begin
      frame_len = CNT_W'(MAX_PIXELS);
    end else begin
      frame_len = CNT_W'(pc_ext);
    end
  end

  assign load_next = CNT_W'(load_cnt_q) + CNT_W'(1);
  assign emit_next = CNT_W'(emit_ptr_q) + CNT_W'(1);

  always_comb begin
    state_d       = state_q;
    pixel_count_d = pixel_count_q;
    run_min_d     = run_min_q;
    run_max_d     = run_max_q;
    load_cnt_d    = load_cnt_q;
    emit_ptr_d    = emit_ptr_q;
    emitting_d    = emitting_q;
    req_min_d     = req_min_q;
    req_max_d     = req_max_q;
    last_pend_d   = last_pend_q;
    out_valid_d   = out_valid_q;
    out_gray_d    = out_gray_q;
    out_last_d    = out_last_q;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = load_cnt_q;
    div_start     = 1'b0;

    if (cfg_we_i) begin
      pixel_count_d = cfg_wdata_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (!emitting_q && mode_i == MODE_LOAD) begin
            ram_en   = 1'b1;
            ram_we   = 1'b1;
            ram_addr = load_cnt_q;
            if (sample_i < run_min_q) begin
              run_min_d = sample_i;
            end
            if (sample_i > run_max_q) begin
              run_max_d = sample_i;
            end
            if (load_next >= frame_len) begin
              emitting_d = 1'b1;
              emit_ptr_d = '0;
              load_cnt_d = '0;
            end else begin
              load_cnt_d = load_next[IDX_W-1:0];
            end
          end else if (emitting_q && mode_i == MODE_EMIT) begin
            ram_en    = 1'b1;
            ram_addr  = emit_ptr_q;
            // bounds of this frame go with the request
            req_min_d = run_min_q;
            req_max_d = run_max_q;
            if (emit_next >= frame_len) begin
              last_pend_d = 1'b1;
              run_min_d   = SAMPLE_TOP;
              run_max_d   = SAMPLE_BOTTOM;
              load_cnt_d  = '0;
              emit_ptr_d  = '0;
              emitting_d  = 1'b0;
            end else begin
              last_pend_d = 1'b0;
              emit_ptr_d  = emit_next[IDX_W-1:0];
            end
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        div_start = 1'b1;
        state_d   = ST_CALC;
      end
      ST_CALC: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_gray_d  = div_gray;
          out_last_d  = last_pend_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      pixel_count_q <= PIXEL_COUNT_RESET;
      run_min_q     <= SAMPLE_TOP;
      run_max_q     <= SAMPLE_BOTTOM;
      load_cnt_q    <= '0;
      emit_ptr_q    <= '0;
      emitting_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      req_min_q     <= '0;
      req_max_q     <= '0;
      last_pend_q   <= 1'b0;
      out_gray_q    <= '0;
      out_last_q    <= 1'b0;
    end else begin
      state_q       <= state_d;
      pixel_count_q <= pixel_count_d;
      run_min_q     <= run_min_d;
      run_max_q     <= run_max_d;
      load_cnt_q    <= load_cnt_d;
      emit_ptr_q    <= emit_ptr_d;
      emitting_q    <= emitting_d;
      out_valid_q   <= out_valid_d;
      req_min_q     <= req_min_d;
      req_max_q     <= req_max_d;
      last_pend_q   <= last_pend_d;
      out_gray_q    <= out_gray_d;
      out_last_q    <= out_last_d;
    end
  end

  mmn_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_PIXELS)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (sample_i),
    .rdata_o (ram_rdata)
  );

  assign div_req.sample = $signed(ram_rdata);
  assign div_req.vmin   = req_min_q;
  assign div_req.vmax   = req_max_q;

  mmn_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .gray_o  (div_gray)
  );

  assign out_valid_o = out_valid_q;
  assign gray_o      = out_gray_q;
  assign last_o      = out_last_q;

endmodule
